### src/dgs_pkg.sv
package dgs_pkg;

	// default sizes, handed to the top level parameters
	localparam int MAX_DIGITS_DEF = 10;
	localparam int COORD_BITS_DEF = 16;

	// fixed field widths
	localparam int VALUE_W    = 32;
	localparam int IN_COORD_W = 16;
	localparam int REG_W      = 14;
	localparam int IN_W       = VALUE_W + 3 * IN_COORD_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// floor(v / 10) = (v * RECIP_DIV10) >> RECIP_SHIFT for every 32-bit v
	localparam logic [VALUE_W-1:0] RECIP_DIV10 = 32'hCCCC_CCCD;
	localparam int                 RECIP_SHIFT = 35;

	// register reset values
	localparam logic [REG_W-1:0] GLYPH_WIDTH_RST  = 14'd1638;
	localparam logic [REG_W-1:0] GLYPH_HEIGHT_RST = 14'd3277;
	localparam logic [REG_W-1:0] DIGIT_PITCH_RST  = 14'd2458;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GLYPH_WIDTH  = 2'd0,
		REG_GLYPH_HEIGHT = 2'd1,
		REG_DIGIT_PITCH  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} seq_state_t;

	// stroke code: {x0, y0[1:0], x1, y1[1:0]}
	typedef logic [5:0] stroke_t;

	localparam logic [1:0] Y_BOTTOM = 2'd0;
	localparam logic [1:0] Y_MIDDLE = 2'd1;
	localparam logic [1:0] Y_TOP    = 2'd2;

	localparam stroke_t STK_NONE  = 6'b0_00_0_00;
	localparam stroke_t STK_LB_LT = 6'b0_00_0_10;
	localparam stroke_t STK_RB_RT = 6'b1_00_1_10;
	localparam stroke_t STK_LT_RT = 6'b0_10_1_10;
	localparam stroke_t STK_LB_RB = 6'b0_00_1_00;
	localparam stroke_t STK_LB_RT = 6'b0_00_1_10;
	localparam stroke_t STK_LB_LM = 6'b0_00_0_01;
	localparam stroke_t STK_LM_RM = 6'b0_01_1_01;
	localparam stroke_t STK_RM_RT = 6'b1_01_1_10;
	localparam stroke_t STK_LM_LT = 6'b0_01_0_10;
	localparam stroke_t STK_RB_RM = 6'b1_00_1_01;

	localparam stroke_t GLYPH_TAB [10][5] = '{
		'{STK_LB_LT, STK_RB_RT, STK_LT_RT, STK_LB_RB, STK_LB_RT},
		'{STK_RB_RT, STK_NONE,  STK_NONE,  STK_NONE,  STK_NONE },
		'{STK_LB_LM, STK_LB_RB, STK_LM_RM, STK_RM_RT, STK_LT_RT},
		'{STK_LB_RB, STK_LM_RM, STK_LT_RT, STK_RB_RT, STK_NONE },
		'{STK_LM_LT, STK_LM_RM, STK_RB_RT, STK_NONE,  STK_NONE },
		'{STK_RB_RM, STK_LB_RB, STK_LM_RM, STK_LM_LT, STK_LT_RT},
		'{STK_LB_LT, STK_LB_RB, STK_LM_RM, STK_RB_RM, STK_LT_RT},
		'{STK_LT_RT, STK_RB_RT, STK_NONE,  STK_NONE,  STK_NONE },
		'{STK_LB_LT, STK_RB_RT, STK_LT_RT, STK_LB_RB, STK_LM_RM},
		'{STK_LM_LT, STK_RB_RT, STK_LT_RT, STK_LB_RB, STK_LM_RM}
	};

	localparam logic [2:0] GLYPH_LEN [10] = '{
		3'd5, 3'd1, 3'd5, 3'd4, 3'd3, 3'd5, 3'd5, 3'd2, 3'd5, 3'd5
	};

	typedef struct packed {
		logic load;
		logic mul;
		logic div;
	} digit_ctrl_t;

	typedef struct packed {
		logic    load;
		stroke_t code;
		logic    last;
	} stroke_req_t;

endpackage

### src/dgs_digit_unit.sv
module dgs_digit_unit #(
	parameter int MAX_DIGITS = dgs_pkg::MAX_DIGITS_DEF,
	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dgs_pkg::digit_ctrl_t        ctrl,
	input  logic [dgs_pkg::VALUE_W-1:0] value,
	input  logic [IDX_W-1:0]            wr_idx,
	input  logic [IDX_W-1:0]            rd_idx,
	output logic                        quot_zero,
	output logic [3:0]                  rd_digit
);
	import dgs_pkg::*;

	logic [VALUE_W-1:0]   num_q;
	logic [2*VALUE_W-1:0] prod_s1;
	logic [3:0]           digit_q [MAX_DIGITS];
	logic [VALUE_W-1:0]   quot;
	logic [3:0]           rem;

	// reciprocal multiply, then remainder from the low bits only
	assign quot      = VALUE_W'(prod_s1 >> RECIP_SHIFT);
	assign rem       = num_q[3:0] - ({quot[0], 3'b000} + {quot[2:0], 1'b0});
	assign quot_zero = (quot == '0);
	assign rd_digit  = digit_q[rd_idx];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			num_q <= value;
		end
		if (ctrl.mul) begin
			prod_s1 <= (2*VALUE_W)'(num_q) * (2*VALUE_W)'(RECIP_DIV10);
		end
		if (ctrl.div) begin
			num_q           <= quot;
			digit_q[wr_idx] <= rem;
		end
	end

	a_rem_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.div |-> rem <= 4'd9)
		else $error("digit out of decimal range");

	a_div_exact: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.div |-> (36'(quot) * 36'd10 + 36'(rem) == 36'(num_q)))
		else $error("reciprocal divide mismatch");

	a_mul_before_div: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.div |-> $past(ctrl.mul))
		else $error("divide step without product");

endmodule

### src/dgs_stroke_unit.sv
module dgs_stroke_unit #(
	parameter int MAX_DIGITS = dgs_pkg::MAX_DIGITS_DEF,
	parameter int COORD_BITS = dgs_pkg::COORD_BITS_DEF,
	localparam int BX_W  = 16 + $clog2(MAX_DIGITS + 1),
	localparam int OUT_W = ((5 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dgs_pkg::stroke_req_t                  req,
	input  logic signed [BX_W-1:0]                bx,
	input  logic signed [dgs_pkg::IN_COORD_W-1:0] oy,
	input  logic signed [dgs_pkg::IN_COORD_W-1:0] oz,
	input  logic [dgs_pkg::REG_W-1:0]             glyph_width,
	input  logic [dgs_pkg::REG_W-1:0]             glyph_height,
	output logic                                  out_free,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [OUT_W-1:0]                      m_tdata,
	output logic                                  m_tlast
);
	import dgs_pkg::*;

	localparam int EXT_W = ((BX_W + 1 > COORD_BITS) ? BX_W + 1 : COORD_BITS) + 1;
	localparam logic signed [EXT_W-1:0] SAT_HI =
		EXT_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

	logic signed [EXT_W-1:0]      bx_e, w_e, oy_e, oz_e;
	logic signed [EXT_W-1:0]      sx_e, sy_e, ex_e, ey_e;
	logic signed [COORD_BITS-1:0] sx, sy, ex, ey, sz;

	function automatic logic [REG_W-1:0] y_off(input logic [1:0] sel,
			input logic [REG_W-1:0] h);
		logic [REG_W-1:0] r;
		case (sel)
			Y_BOTTOM: r = '0;
			Y_MIDDLE: r = {1'b0, h[REG_W-1:1]};
			default:  r = h;
		endcase
		return r;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [EXT_W-1:0] v);
		logic signed [COORD_BITS-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[COORD_BITS-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[COORD_BITS-1:0];
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

	assign bx_e = EXT_W'(bx);
	assign w_e  = EXT_W'($signed({1'b0, glyph_width}));
	assign oy_e = EXT_W'(oy);
	assign oz_e = EXT_W'(oz);

	assign sx_e = bx_e + (req.code[5] ? w_e : EXT_W'(0));
	assign ex_e = bx_e + (req.code[2] ? w_e : EXT_W'(0));
	assign sy_e = oy_e + EXT_W'($signed({1'b0, y_off(req.code[4:3], glyph_height)}));
	assign ey_e = oy_e + EXT_W'($signed({1'b0, y_off(req.code[1:0], glyph_height)}));

	assign sx = sat(sx_e);
	assign sy = sat(sy_e);
	assign ex = sat(ex_e);
	assign ey = sat(ey_e);
	assign sz = sat(oz_e);

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (req.load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			m_tdata <= OUT_W'({sz, ey, ex, sy, sx});
			m_tlast <= req.last;
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.load |-> out_free)
		else $error("stroke loaded over a waiting item");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		req.load |=> m_tvalid)
		else $error("loaded stroke not presented");

	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		req.load |-> (req.code[4:3] != 2'b11) && (req.code[1:0] != 2'b11))
		else $error("illegal stroke height select");

endmodule

### src/decimal_digit_stroke_generator.sv
// channel  dir  handshake                 payload
// s_*      in   s_tvalid / s_tready       s_tdata: value, origin_x, origin_y, origin_z
// m_*      out  m_tvalid / m_tready       m_tdata: start_x..stroke_z, m_tlast: last_stroke
// cfg_*    in   cfg_valid / cfg_ready     cfg_index, cfg_data (low 14 bits kept)
//
// an item passes each decimal digit through the shared reciprocal divider
// (multiply, then quotient/remainder), then emits its strokes one by one
// s_tready is high only while idle; one output register holds the current stroke
// a stalled m_tready holds the stroke sequencer, nothing is dropped
// asynchronous active-low reset clears the sequencer and restores register defaults
module decimal_digit_stroke_generator #(
	parameter int MAX_DIGITS = dgs_pkg::MAX_DIGITS_DEF,
	parameter int COORD_BITS = dgs_pkg::COORD_BITS_DEF,
	localparam int OUT_W = ((5 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// value [31:0], origin_x [47:32], origin_y [63:48], origin_z [79:64]
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [dgs_pkg::IN_W-1:0]       s_tdata,
	// start_x, start_y, end_x, end_y, stroke_z, COORD_BITS each from the lowest bit up
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [OUT_W-1:0]               m_tdata,
	output logic                           m_tlast,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dgs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dgs_pkg::*;

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int BX_W  = 16 + $clog2(MAX_DIGITS + 1);

	seq_state_t state_q, state_d;

	// configuration registers
	logic [REG_W-1:0] width_q, height_q, pitch_q;

	// sequencer counters
	logic [CNT_W-1:0] ndig_q;     // digits found so far
	logic [IDX_W-1:0] dig_idx_q;  // digit being drawn, least significant first
	logic [2:0]       k_q;        // stroke within the glyph

	// per-item payload: running glyph x, shared y and z
	logic signed [BX_W-1:0]       bx_q;
	logic signed [IN_COORD_W-1:0] oy_q, oz_q;

	digit_ctrl_t dctl;
	stroke_req_t sreq;
	logic        quot_zero;
	logic [3:0]  cur_digit;
	logic        out_free;
	logic        glyph_end;
	logic        digit_last;
	logic        more_room;
	logic        step_bx;
	logic signed [BX_W-1:0] pitch_ext, pitch_term;

	assign cfg_ready = 1'b1;

	// input fields
	logic [VALUE_W-1:0]           in_value;
	logic signed [IN_COORD_W-1:0] in_ox, in_oy, in_oz;
	assign in_value = s_tdata[VALUE_W-1:0];
	assign in_ox    = s_tdata[VALUE_W+IN_COORD_W-1:VALUE_W];
	assign in_oy    = s_tdata[VALUE_W+2*IN_COORD_W-1:VALUE_W+IN_COORD_W];
	assign in_oz    = s_tdata[VALUE_W+3*IN_COORD_W-1:VALUE_W+2*IN_COORD_W];

	// shared divide-by-ten unit and digit store
	dgs_digit_unit #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_digit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (dctl),
		.value     (in_value),
		.wr_idx    (ndig_q[IDX_W-1:0]),
		.rd_idx    (dig_idx_q),
		.quot_zero (quot_zero),
		.rd_digit  (cur_digit)
	);

	// stroke endpoint adders, saturation and output register
	dgs_stroke_unit #(
		.MAX_DIGITS(MAX_DIGITS),
		.COORD_BITS(COORD_BITS)
	) u_stroke (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (sreq),
		.bx           (bx_q),
		.oy           (oy_q),
		.oz           (oz_q),
		.glyph_width  (width_q),
		.glyph_height (height_q),
		.out_free     (out_free),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

	// keep dividing while the quotient is non-zero and there is room for a digit
	assign more_room  = ndig_q < CNT_W'(MAX_DIGITS - 1);
	assign glyph_end  = (k_q == GLYPH_LEN[cur_digit] - 3'd1);
	assign digit_last = (CNT_W'(dig_idx_q) == ndig_q - CNT_W'(1));

	// one add/subtract for the glyph x: plus pitch per extra digit, minus per drawn digit
	assign pitch_ext  = BX_W'($signed({1'b0, pitch_q}));
	assign pitch_term = (state_q == ST_DIV) ? pitch_ext : -pitch_ext;
	assign step_bx    = (dctl.div && state_d == ST_MUL) || (sreq.load && glyph_end);

	always_comb begin
		state_d  = state_q;
		dctl     = '0;
		sreq     = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					dctl.load = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				dctl.mul = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				dctl.div = 1'b1;
				if (!quot_zero && more_room) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					sreq.load = 1'b1;
					sreq.code = GLYPH_TAB[cur_digit][k_q];
					sreq.last = glyph_end && digit_last;
					if (sreq.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ndig_q    <= '0;
			dig_idx_q <= '0;
			k_q       <= '0;
		end else begin
			state_q <= state_d;
			if (dctl.load) begin
				ndig_q    <= '0;
				dig_idx_q <= '0;
				k_q       <= '0;
			end
			if (dctl.div) begin
				ndig_q <= ndig_q + CNT_W'(1);
			end
			if (sreq.load) begin
				if (glyph_end) begin
					k_q       <= '0;
					dig_idx_q <= dig_idx_q + IDX_W'(1);
				end else begin
					k_q <= k_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= GLYPH_WIDTH_RST;
			height_q <= GLYPH_HEIGHT_RST;
			pitch_q  <= DIGIT_PITCH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GLYPH_WIDTH:  width_q  <= cfg_data[REG_W-1:0];
				REG_GLYPH_HEIGHT: height_q <= cfg_data[REG_W-1:0];
				REG_DIGIT_PITCH:  pitch_q  <= cfg_data[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dctl.load) begin
			bx_q <= BX_W'(in_ox);
			oy_q <= in_oy;
			oz_q <= in_oz;
		end else if (step_bx) begin
			bx_q <= bx_q + pitch_term;
		end
	end

	a_emit_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (ndig_q != '0) && (ndig_q <= CNT_W'(MAX_DIGITS)))
		else $error("drawing with no digits");

	a_emit_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> CNT_W'(dig_idx_q) < ndig_q)
		else $error("digit index past digit count");

	a_div_room: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.div |-> ndig_q < CNT_W'(MAX_DIGITS))
		else $error("digit store overrun");

endmodule
